// ===== rtl/hnc_pkg.sv =====
// Shared constants and types for the hum notch cascade.
`default_nettype none

package hnc_pkg;

  // Build constants
  localparam int MaxStages   = 4;
  localparam int SampleW     = 24;
  localparam int CoefW       = 20;
  localparam int HistW       = 32;

  // Register map
  localparam int NumCoefRegs = 4;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 3 * CoefW;
  localparam int StagesW     = 3;
  localparam logic [CfgIdxW-1:0] CfgStagesInUse = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStage1Coef  = 3'd1;

  // Derived widths
  localparam int StageW = (MaxStages > 1) ? $clog2(MaxStages) : 1;
  localparam int CntW   = $clog2(MaxStages + 1);
  localparam int OpW    = HistW + 1;
  localparam int ProdW  = OpW + CoefW;
  localparam int AccW   = ProdW + 1;
  localparam int DropW  = CoefW - 2;
  localparam int RndW   = AccW + 1;
  localparam int ShW    = RndW - DropW;

  // One stage's history: last two inputs and last two outputs
  typedef struct packed {
    logic signed [HistW-1:0] x1;
    logic signed [HistW-1:0] x2;
    logic signed [HistW-1:0] y1;
    logic signed [HistW-1:0] y2;
  } hist_row_t;

  // Sequencer control for the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic acc_sub;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/hnc_mac.sv =====
// Shared multiplier with registered product and accumulator.
`default_nettype none

module hnc_mac (
  input  wire                                logic clk_i,
  input  wire                                logic rst_ni,
  input  wire hnc_pkg::mac_ctl_t             ctl_i,
  input  wire logic signed [hnc_pkg::OpW-1:0]   opa_i,
  input  wire logic signed [hnc_pkg::CoefW-1:0] coef_i,
  output logic signed [hnc_pkg::AccW-1:0]       acc_o
);

  logic signed [hnc_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [hnc_pkg::AccW-1:0]  acc_d, acc_q;
  logic signed [hnc_pkg::AccW-1:0]  prod_ext;

  assign prod_d   = opa_i * coef_i;
  assign prod_ext = hnc_pkg::AccW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctl_i.acc_en) begin
      acc_d = ctl_i.acc_sub ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  // product and accumulator are payload; rst_ni is used only by the assertions
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

  // clear and accumulate never come together
  a_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.acc_clr && ctl_i.acc_en))
    else $error("accumulator clear with accumulate");

  // a cleared accumulator reads zero next cycle
  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.acc_clr |=> (acc_o == '0))
    else $error("accumulator not cleared");

  // accumulator only moves when told
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctl_i.acc_clr && !ctl_i.acc_en) |=> $stable(acc_o))
    else $error("accumulator changed while idle");

endmodule

`default_nettype wire

// ===== rtl/hnc_hist.sv =====
// Per-stage filter history rows with valid bits for clearing all rows at once.
`default_nettype none

module hnc_hist (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              clr_all_i,
  input  wire logic [hnc_pkg::StageW-1:0]        rd_idx_i,
  output hnc_pkg::hist_row_t                     rd_row_o,
  input  wire logic                              wr_en_i,
  input  wire logic [hnc_pkg::StageW-1:0]        wr_idx_i,
  input  wire hnc_pkg::hist_row_t                wr_row_i
);

  hnc_pkg::hist_row_t                 row_q [hnc_pkg::MaxStages];
  logic [hnc_pkg::MaxStages-1:0]      valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_all_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_q[wr_idx_i] <= wr_row_i;
    end
  end

  // an invalid row reads as cleared history
  assign rd_row_o = valid_q[rd_idx_i] ? row_q[rd_idx_i] : '0;

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_all_i |=> (valid_q == '0))
    else $error("history clear left valid rows");

  a_no_wr_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_all_i && wr_en_i))
    else $error("history write during clear");

  a_wr_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> valid_q[$past(wr_idx_i)])
    else $error("written row not valid");

endmodule

`default_nettype wire

// ===== rtl/hum_notch_cascade_core.sv =====
// Top level: hum remover, cascaded DF-I notch biquads on one shared MAC.
//
// Input channel: in_valid_i / in_stall_o carry one transaction per audio
// sample (sample_in_i, Q1.23, and start_of_buffer_i). A transaction is taken
// at a rising edge with in_valid_i high and in_stall_o low. start_of_buffer_i
// clears every stage history before that sample is filtered.
// Output channel: out_valid_o / out_stall_i carry one filtered sample
// (sample_out_o, Q1.23, saturated) per input transaction, in order.
// Config: cfg_we_i writes cfg_data_i to register cfg_index_i (0 = stages in
// use, 1..4 = packed Q2.18 g/c/r of stage 1..4); write only while idle.
// Timing: each stage runs on the shared multiplier as three products, the last
// accumulate, then round/saturate and history update. After the last stage in
// use the result is registered from ST_OUT and the input is taken again from
// ST_IDLE; a new sample is not accepted until the last one is registered.
// n = 0 goes straight from acceptance to ST_OUT to register the sample.
// The output register decouples the sides: a new sample is accepted and
// filtered while the previous result waits; the sequencer holds in its final
// step only if the output register is still full and stalled.
// Reset: histories clear, stages in use = 1, coefficients zero, no output.
`default_nettype none

module hum_notch_cascade_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [hnc_pkg::SampleW-1:0] sample_in_i,
  input  wire logic                               start_of_buffer_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [hnc_pkg::SampleW-1:0]      sample_out_o,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [hnc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [hnc_pkg::CfgDataW-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam int CW = hnc_pkg::CoefW;
  localparam int HW = hnc_pkg::HistW;
  localparam int SW = hnc_pkg::SampleW;

  // MAC step within one stage: three products, then the trailing accumulate
  localparam logic [1:0] TermGain   = 2'd0;
  localparam logic [1:0] TermCos    = 2'd1;
  localparam logic [1:0] TermRadius = 2'd2;
  localparam logic [1:0] TermLast   = 2'd3;

  state_e                          state_q, state_d;
  logic [1:0]                      term_q, term_d;
  logic [hnc_pkg::StageW-1:0]      stage_q, stage_d;
  logic [hnc_pkg::CntW-1:0]        n_q, n_d;
  logic signed [HW-1:0]            x_q, x_d;

  logic [hnc_pkg::StagesW-1:0]     stages_q;
  logic [hnc_pkg::CfgDataW-1:0]    coef_q [hnc_pkg::MaxStages];

  logic                            out_valid_q, out_valid_d;
  logic signed [SW-1:0]            sample_out_q;

  // --- config registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= hnc_pkg::StagesW'(1);
      for (int k = 0; k < hnc_pkg::MaxStages; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == hnc_pkg::CfgStagesInUse) begin
        stages_q <= cfg_data_i[hnc_pkg::StagesW-1:0];
      end
      // stages beyond the register map keep zero coefficients
      for (int k = 0; k < hnc_pkg::MaxStages; k++) begin
        if (k < hnc_pkg::NumCoefRegs &&
            cfg_index_i == hnc_pkg::CfgStage1Coef + hnc_pkg::CfgIdxW'(k)) begin
          coef_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // --- effective stage count, clipped to what is built ---
  logic [hnc_pkg::CntW-1:0] n_eff;
  always_comb begin
    if (32'(stages_q) > hnc_pkg::MaxStages) begin
      n_eff = hnc_pkg::CntW'(hnc_pkg::MaxStages);
    end else begin
      n_eff = hnc_pkg::CntW'(stages_q);
    end
  end

  // --- history rows ---
  hnc_pkg::hist_row_t row_rd, row_wr;
  logic               hist_clr, hist_we;

  hnc_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_all_i (hist_clr),
    .rd_idx_i  (stage_q),
    .rd_row_o  (row_rd),
    .wr_en_i   (hist_we),
    .wr_idx_i  (stage_q),
    .wr_row_i  (row_wr)
  );

  // --- shared MAC: operand and coefficient select per term ---
  hnc_pkg::mac_ctl_t               mac_ctl;
  logic signed [hnc_pkg::OpW-1:0]  mac_opa;
  logic signed [CW-1:0]            mac_coef;
  logic signed [hnc_pkg::AccW-1:0] mac_acc;
  logic [hnc_pkg::CfgDataW-1:0]    coef_sel;

  assign coef_sel = coef_q[stage_q];

  always_comb begin
    unique case (term_q)
      TermGain: begin
        mac_opa  = hnc_pkg::OpW'(x_q) + hnc_pkg::OpW'(row_rd.x2);
        mac_coef = coef_sel[3*CW-1:2*CW];
      end
      TermCos: begin
        mac_opa  = hnc_pkg::OpW'(row_rd.x1) - hnc_pkg::OpW'(row_rd.y1);
        mac_coef = coef_sel[2*CW-1:CW];
      end
      TermRadius: begin
        mac_opa  = hnc_pkg::OpW'(row_rd.y2);
        mac_coef = coef_sel[CW-1:0];
      end
      default: begin
        mac_opa  = '0;
        mac_coef = '0;
      end
    endcase
  end

  hnc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .opa_i  (mac_opa),
    .coef_i (mac_coef),
    .acc_o  (mac_acc)
  );

  // --- round half up, drop fraction bits, saturate to history width ---
  logic signed [hnc_pkg::RndW-1:0] rnd_sum;
  logic signed [hnc_pkg::ShW-1:0]  rnd_sh;
  logic signed [HW-1:0]            y_sat;

  assign rnd_sum = hnc_pkg::RndW'(mac_acc) +
                   (hnc_pkg::RndW'(1) <<< (hnc_pkg::DropW - 1));
  assign rnd_sh  = hnc_pkg::ShW'(rnd_sum >>> hnc_pkg::DropW);

  always_comb begin
    if (&rnd_sh[hnc_pkg::ShW-1:HW-1] || ~|rnd_sh[hnc_pkg::ShW-1:HW-1]) begin
      y_sat = rnd_sh[HW-1:0];
    end else begin
      y_sat = {rnd_sh[hnc_pkg::ShW-1], {(HW-1){~rnd_sh[hnc_pkg::ShW-1]}}};
    end
  end

  // stage shift: new input/output become x1/y1, old x1/y1 move to x2/y2
  always_comb begin
    row_wr.x1 = x_q;
    row_wr.x2 = row_rd.x1;
    row_wr.y1 = y_sat;
    row_wr.y2 = row_rd.y1;
  end

  // --- final saturation to sample width ---
  logic signed [SW-1:0] out_sat;
  always_comb begin
    if (&x_q[HW-1:SW-1] || ~|x_q[HW-1:SW-1]) begin
      out_sat = x_q[SW-1:0];
    end else begin
      out_sat = {x_q[HW-1], {(SW-1){~x_q[HW-1]}}};
    end
  end

  logic in_take, out_take, out_load, last_stage;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign last_stage  = (hnc_pkg::CntW'(stage_q) + hnc_pkg::CntW'(1)) == n_q;

  // --- sequencer ---
  always_comb begin
    state_d  = state_q;
    term_d   = term_q;
    stage_d  = stage_q;
    n_d      = n_q;
    x_d      = x_q;
    hist_clr = 1'b0;
    hist_we  = 1'b0;
    mac_ctl  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          hist_clr = start_of_buffer_i;
          x_d      = HW'(sample_in_i);
          n_d      = n_eff;
          stage_d  = '0;
          term_d   = TermGain;
          state_d  = (n_eff == '0) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en  = (term_q != TermLast);
        mac_ctl.acc_clr = (term_q == TermGain);
        mac_ctl.acc_en  = (term_q != TermGain);
        mac_ctl.acc_sub = (term_q == TermLast);   // subtract r*y2
        term_d          = term_q + 2'd1;
        if (term_q == TermLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        hist_we = 1'b1;
        x_d     = y_sat;
        term_d  = TermGain;
        if (last_stage) begin
          state_d = ST_OUT;
        end else begin
          stage_d = stage_q + hnc_pkg::StageW'(1);
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TermGain;
      stage_q     <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      stage_q     <= stage_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (out_load) begin
      sample_out_q <= out_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  // --- assertions ---
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_FIN) |-> (hnc_pkg::CntW'(stage_q) < n_q))
    else $error("stage index beyond stages in use");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && n_eff == '0) |=> (state_q == ST_OUT))
    else $error("zero-stage sample not passed straight through");

  a_fin_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=>
      ((state_q == ST_MUL && term_q == TermGain) || state_q == ST_OUT))
    else $error("bad step after stage finish");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared without finishing a sample");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (state_q == ST_IDLE))
    else $error("config write while busy");

endmodule

`default_nettype wire

// ===== dv/tb_hum_notch_cascade_core.sv =====
// Self-checking testbench for hum_notch_cascade_core: directed and random samples vs. a notch model.
module tb_hum_notch_cascade_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Build constants taken from the design package
  localparam int MaxStages   = hnc_pkg::MaxStages;
  localparam int SampleW     = hnc_pkg::SampleW;
  localparam int CoefW       = hnc_pkg::CoefW;
  localparam int HistW       = hnc_pkg::HistW;
  localparam int NumCoefRegs = hnc_pkg::NumCoefRegs;
  localparam int CfgIdxW     = hnc_pkg::CfgIdxW;
  localparam int CfgDataW    = hnc_pkg::CfgDataW;
  localparam int StagesW     = hnc_pkg::StagesW;
  localparam int DropW       = hnc_pkg::DropW;
  localparam logic [CfgIdxW-1:0] CfgStagesInUse = hnc_pkg::CfgStagesInUse;
  localparam logic [CfgIdxW-1:0] CfgStage1Coef  = hnc_pkg::CfgStage1Coef;

  // Run shape
  localparam int  CycleLimit   = 600000;  // watchdog bound on the whole run
  localparam int  SettleCycles = 40;      // idle margin after the last result, before cfg
  localparam int  RandPhases   = 10;
  localparam int  PhaseItems   = 115;
  localparam real Pi           = 3.14159265358979;
  localparam real NotchQ       = 30.0;

  // Numeric rails
  localparam longint HistHi   = (longint'(1) <<< (HistW - 1)) - 1;
  localparam longint HistLo   = -HistHi - 1;
  localparam longint SampleHi = (longint'(1) <<< (SampleW - 1)) - 1;
  localparam longint SampleLo = -SampleHi - 1;
  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};
  localparam logic [CoefW-1:0] CoefOne = CoefW'(1) << DropW;

  typedef enum int {RxOpen, RxLight, RxHeavy, RxBeat} rx_mode_e;
  typedef enum int {WaveNoise, WaveQuiet, WaveHum, WaveRails} wave_e;
  typedef enum int {CoefHum, CoefRandom, CoefRailHigh, CoefRailLow, CoefUnity} coef_kind_e;

  // DUT connections
  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic                      start_of_buffer_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgDataW-1:0]       cfg_data_i;

  // Bit-true copy of the cascade: histories, register file and the queue of
  // filtered samples still owed by the DUT.
  class notch_tracker;
    logic signed [HistW-1:0]   x_hist [2*MaxStages];
    logic signed [HistW-1:0]   y_hist [2*MaxStages];
    logic        [StagesW-1:0] stages_cfg;
    logic signed [CoefW-1:0]   gain   [MaxStages];
    logic signed [CoefW-1:0]   cosine [MaxStages];
    logic signed [CoefW-1:0]   radius [MaxStages];
    logic signed [SampleW-1:0] filtered_due [$];
    int n_samples;
    int n_errors;
    int n_clipped;

    function void clear_history();
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
    endfunction

    function void reset_state();
      clear_history();
      stages_cfg = StagesW'(1);
      foreach (gain[k]) begin
        gain[k]   = '0;
        cosine[k] = '0;
        radius[k] = '0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      int k;
      if (idx == CfgStagesInUse) begin
        stages_cfg = data[StagesW-1:0];
      end else if (idx >= CfgStage1Coef && idx < CfgStage1Coef + NumCoefRegs) begin
        k = int'(idx - CfgStage1Coef);
        if (k < MaxStages) begin
          radius[k] = data[CoefW-1:0];
          cosine[k] = data[2*CoefW-1:CoefW];
          gain[k]   = data[3*CoefW-1:2*CoefW];
        end
      end
      // indexes past the coefficient block are dropped
    endfunction

    function int outstanding();
      return filtered_due.size();
    endfunction

    // One accepted sample: run it through the active stages, queue the result.
    function void note_sample(logic signed [SampleW-1:0] s, logic sob);
      longint x, x1, x2, y1, y2, acc;
      int n, k;
      n = (stages_cfg > MaxStages) ? MaxStages : int'(stages_cfg);
      x = s;
      if (sob) clear_history();
      for (k = 0; k < n; k++) begin
        x1  = x_hist[2*k];
        x2  = x_hist[2*k+1];
        y1  = y_hist[2*k];
        y2  = y_hist[2*k+1];
        acc = longint'(gain[k]) * (x + x2) + longint'(cosine[k]) * (x1 - y1)
              - longint'(radius[k]) * y2;
        // round half up, drop DropW fraction bits, clip to history width
        acc = (acc + (longint'(1) <<< (DropW - 1))) >>> DropW;
        if (acc > HistHi) acc = HistHi;
        else if (acc < HistLo) acc = HistLo;
        x_hist[2*k+1] = x_hist[2*k];
        x_hist[2*k]   = x[HistW-1:0];
        y_hist[2*k+1] = y_hist[2*k];
        y_hist[2*k]   = acc[HistW-1:0];
        x = acc;
      end
      if (x > SampleHi) begin
        x = SampleHi;
        n_clipped++;
      end else if (x < SampleLo) begin
        x = SampleLo;
        n_clipped++;
      end
      filtered_due.insert(filtered_due.size(), x[SampleW-1:0]);
      n_samples++;
    endfunction

    function void check_sample(logic signed [SampleW-1:0] got);
      logic signed [SampleW-1:0] want;
      if (filtered_due.size() == 0) begin
        $error("sample_out: expected nothing pending, actual %0d", got);
        n_errors++;
        return;
      end
      want = filtered_due.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", want, got);
        n_errors++;
      end
    endfunction
  endclass

  notch_tracker tracker;
  rx_mode_e     stall_mode;
  int           holdoff_len;
  bit           gaps_on;
  int           burst_left;
  int           n_settings;
  int           cycle_count;
  logic [CfgDataW-1:0] coef_set [NumCoefRegs];

  hum_notch_cascade_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_in_i       (sample_in_i),
    .start_of_buffer_i (start_of_buffer_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_out_o      (sample_out_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Real value to a saturated coefficient field.
  function automatic logic [CoefW-1:0] to_coef(real v);
    int q;
    q = $rtoi(v * real'(longint'(1) << DropW));
    if (q > int'(CoefMax)) q = int'(CoefMax);
    if (q < -int'(CoefMax) - 1) q = -int'(CoefMax) - 1;
    return q[CoefW-1:0];
  endfunction

  // Packed {g, c, r} for one stage. Hum kind is the normalized notch at freq.
  function automatic logic [CfgDataW-1:0] stage_coefs(coef_kind_e kind, real freq, real rate);
    real w, alpha;
    case (kind)
      CoefHum: begin
        w     = 2.0 * Pi * freq / rate;
        alpha = $sin(w) / (2.0 * NotchQ);
        return {to_coef(1.0 / (1.0 + alpha)), to_coef(-2.0 * $cos(w) / (1.0 + alpha)),
                to_coef((1.0 - alpha) / (1.0 + alpha))};
      end
      CoefRailHigh: return {CoefMax, CoefMax, CoefMax};
      CoefRailLow:  return {CoefMin, CoefMin, CoefMin};
      CoefUnity:    return {CoefOne, {(2*CoefW){1'b0}}};
      default:      return CfgDataW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] make_sample(wave_e wave, int n, real step);
    case (wave)
      WaveNoise: return SampleW'($urandom);
      WaveQuiet: return SampleW'(int'($urandom_range(0, 4095)) - 2048);
      WaveHum:   return SampleW'($rtoi(6.0e6 * $sin(step * n))
                                 + int'($urandom_range(0, 255)) - 128);
      default:   return ($urandom_range(0, 1) != 0) ? SampleMax : SampleMin;
    endcase
  endfunction

  // Offer one sample; returns at the edge that took it. Valid only drops for
  // a gap between bursts, never while a transaction is pending.
  task automatic send_sample(input logic signed [SampleW-1:0] s, input logic sob);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i        <= 1'b1;
    sample_in_i       <= s;
    start_of_buffer_i <= sob;
    // stall sampled mid-cycle equals its value at the next edge
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_sample(s, sob);
    @(posedge clk_i);
  endtask

  // Stop offering, wait out every owed result, then let the pipe go quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Full register load; poke_spare also hits the unused indexes above the map.
  task automatic load_filter(input logic [StagesW-1:0] stages, input bit poke_spare);
    write_reg(CfgStagesInUse, CfgDataW'(stages));
    for (int k = 0; k < NumCoefRegs; k++)
      write_reg(CfgStage1Coef + CfgIdxW'(k), coef_set[k]);
    if (poke_spare)
      for (int i = CfgStage1Coef + NumCoefRegs; i < (1 << CfgIdxW); i++)
        write_reg(CfgIdxW'(i), CfgDataW'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side backpressure: a mode picked per phase, plus one-off long
  // hold-offs requested through holdoff_len.
  initial begin : receiver
    int rx_tick;
    rx_tick = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (holdoff_len) @(posedge clk_i);
        holdoff_len = 0;
      end
      case (stall_mode)
        RxOpen:  out_stall_i <= 1'b0;
        RxLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        RxHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ((rx_tick % 7) < 3);
      endcase
      rx_tick++;
    end
  end

  // Result check: outputs settle by mid-cycle, sample there.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      tracker.check_sample(sample_out_o);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_hum_notch_cascade_core: timeout after %0d cycles", cycle_count);
    $display("tb_hum_notch_cascade_core: done, errors");
    $finish;
  end

  initial begin : stimulus
    int                  phase, sent, buf_len, i;
    bit                  first, hum_phase;
    logic                sob;
    real                 base, rate, step;
    wave_e               wave;
    logic [StagesW-1:0]  stages;

    tracker = new();
    tracker.reset_state();
    stall_mode  = RxOpen;
    holdoff_len = 0;
    gaps_on     = 1'b0;
    burst_left  = 0;
    n_settings  = 0;

    rst_ni            <= 1'b0;
    in_valid_i        <= 1'b0;
    sample_in_i       <= '0;
    start_of_buffer_i <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    gaps_on    = 1'b1;
    stall_mode = RxLight;

    // reset registers: one stage, zero coefficients, everything filters to 0
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMin, 1'b0);
    drain_results();

    // four hum notches, 50 Hz base at 48 kHz; full scale steps and small values
    for (int k = 0; k < NumCoefRegs; k++)
      coef_set[k] = stage_coefs(CoefHum, 50.0 * (k + 1), 48000.0);
    load_filter(StagesW'(MaxStages), 1'b0);
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SampleW'(1), 1'b0);
    send_sample('1, 1'b0);
    send_sample({(SampleW/2){2'b01}}, 1'b1);
    send_sample({(SampleW/2){2'b10}}, 1'b0);
    drain_results();

    // zero stages is a straight pass; also write the indexes past the map
    load_filter('0, 1'b1);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b1);
    send_sample('1, 1'b0);
    send_sample({(SampleW/2){2'b10}}, 1'b0);
    drain_results();

    // stage count above the build clamps; rail coefficients drive both clips
    coef_set[0] = stage_coefs(CoefRailHigh, 0.0, 1.0);
    coef_set[1] = stage_coefs(CoefRailLow, 0.0, 1.0);
    coef_set[2] = stage_coefs(CoefUnity, 0.0, 1.0);
    coef_set[3] = stage_coefs(CoefRandom, 0.0, 1.0);
    load_filter('1, 1'b0);
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    drain_results();

    // drop to one stage without a clear: stages 2..4 keep their history
    load_filter(StagesW'(1), 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    drain_results();

    // ---- random phases: new setting each, buffers after the first led by a start flag ----
    for (phase = 0; phase < RandPhases; phase++) begin
      hum_phase = ($urandom_range(0, 9) < 6);
      base      = ($urandom_range(0, 1) != 0) ? 50.0 : 60.0;
      rate      = 8000.0 * (1 + $urandom_range(0, 5));
      for (int k = 0; k < NumCoefRegs; k++)
        coef_set[k] = stage_coefs(hum_phase ? CoefHum
                                            : coef_kind_e'($urandom_range(CoefHum, CoefUnity)),
                                  base * (k + 1), rate);
      stages = ($urandom_range(0, 3) != 0) ? StagesW'($urandom_range(1, MaxStages))
                                           : StagesW'($urandom);
      load_filter(stages, 1'b0);
      stall_mode = rx_mode_e'($urandom_range(RxOpen, RxBeat));
      gaps_on    = ($urandom_range(0, 2) != 0);
      if (phase % 5 == 2) begin
        // long receiver hold-off with the sender pushing: input must stall
        gaps_on     = 1'b0;
        holdoff_len = 300;
      end

      sent  = 0;
      first = 1'b1;
      while (sent < PhaseItems) begin
        buf_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 64);
        wave    = wave_e'($urandom_range(WaveNoise, WaveRails));
        step    = 2.0 * Pi * base * $urandom_range(1, MaxStages) / rate;
        for (i = 0; i < buf_len && sent < PhaseItems; i++) begin
          // first buffer of a phase may continue the old history; rare stray clears
          sob = (i == 0) ? (!first || $urandom_range(0, 1) == 0)
                         : ($urandom_range(0, 49) == 0);
          send_sample(make_sample(wave, i, step), sob);
          sent++;
          // sender goes quiet until every owed result is back
          if (phase % 5 == 4 && sent == PhaseItems / 2) drain_results();
        end
        first = 1'b0;
      end
      drain_results();
    end

    $display("covered %0d samples over %0d filter settings, stage counts 0 to 7",
             tracker.n_samples, n_settings);
    $display("%0d results clipped at full scale, %0d mismatches",
             tracker.n_clipped, tracker.n_errors);
    if (tracker.n_errors == 0)
      $display("tb_hum_notch_cascade_core: done, clean");
    else
      $display("tb_hum_notch_cascade_core: done, errors");
    $finish;
  end

endmodule
